### sv/cau_pkg.sv
// ----------------------------------------------------------------------------
// cau_pkg
// Shared types and defaults for the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

    localparam int DATA_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF  = 8;

    typedef enum logic [1:0] {
        FUNC_ADD = 2'd0,
        FUNC_SUB = 2'd1,
        FUNC_MUL = 2'd2,
        FUNC_DIV = 2'd3
    } t_func;

endpackage

### sv/complex_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// Pipelined complex add, subtract, multiply and divide on signed fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_valid / o_stall with i_func and the operands a and b.
//   A transfer happens at a clock edge with i_valid high and o_stall low.
//   Output channel: o_valid / i_stall with the result parts and the flags.
//   Every item gives exactly one result, in order.
//   Pipeline: input registers, products, sums, division set-up, then the
//   restoring divider that resolves one quotient bit per stage, then output.
//   Throughput: one item per cycle unless stalled; all functions share the same pipeline.
//   Reset (i_rst_n low, synchronous) empties the pipeline.
//   When the receiver stalls, the result holds; stages behind it keep
//   filling empty slots, and o_stall rises only when no slot is free.
//   Multiply drops fraction bits (floor), divide truncates toward zero,
//   every part saturates with o_overflow; a zero divisor gives 0 with
//   o_div_by_zero.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit
    import cau_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [1:0]                   i_func,
    input  logic signed [DATA_WIDTH-1:0] i_a_re,
    input  logic signed [DATA_WIDTH-1:0] i_a_im,
    input  logic signed [DATA_WIDTH-1:0] i_b_re,
    input  logic signed [DATA_WIDTH-1:0] i_b_im,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [DATA_WIDTH-1:0] o_res_re,
    output logic signed [DATA_WIDTH-1:0] o_res_im,
    output logic                         o_overflow,
    output logic                         o_div_by_zero
);

    localparam int W  = DATA_WIDTH;
    localparam int PW = 2 * W;
    localparam int SW = PW + 1;
    localparam int NW = SW + FRAC_BITS;
    localparam int CW = (NW > 3 * W) ? NW : 3 * W;

    typedef struct packed {
        logic [W-1:0] v;
        logic         o;
    } t_sat;

    typedef struct packed {
        t_func         func;
        logic          dz;
        logic [W-1:0]  ar_re;
        logic [W-1:0]  ar_im;
        logic          ar_ovf;
        logic          neg_re;
        logic          neg_im;
        logic          sat_re;
        logic          sat_im;
        logic [CW-1:0] r_re;
        logic [CW-1:0] r_im;
        logic [PW-1:0] den;
        logic [W-1:0]  q_re;
        logic [W-1:0]  q_im;
    } t_dv;

    function automatic t_sat sat_s(input logic signed [SW-1:0] x);
        t_sat r;
        logic signed [SW-1:0] mx;
        logic signed [SW-1:0] mn;
        mx = SW'((64'sd1 <<< (W - 1)) - 64'sd1);
        mn = -mx - SW'(1);
        if (x > mx) begin
            r.v = mx[W-1:0];
            r.o = 1'b1;
        end else if (x < mn) begin
            r.v = mn[W-1:0];
            r.o = 1'b1;
        end else begin
            r.v = x[W-1:0];
            r.o = 1'b0;
        end
        return r;
    endfunction

    function automatic t_sat div_fin(input logic neg, input logic sat, input logic [W-1:0] q);
        t_sat r;
        logic big_neg;
        big_neg = q[W-1] && (q[W-2:0] != '0);
        r.o = 1'b0;
        if (neg) begin
            if (sat || big_neg) begin
                r.v = {1'b1, {(W-1){1'b0}}};
                r.o = 1'b1;
            end else begin
                r.v = W'(-q);
            end
        end else begin
            if (sat || q[W-1]) begin
                r.v = {1'b0, {(W-1){1'b1}}};
                r.o = 1'b1;
            end else begin
                r.v = q;
            end
        end
        return r;
    endfunction

    // stage 0: input registers
    logic                r_v0;
    t_func               r_func0;
    logic signed [W-1:0] r_a_re, r_a_im, r_b_re, r_b_im;

    // stage 1: products and add/sub
    logic                 r_v1;
    t_func                r_func1;
    logic signed [PW-1:0] r_p_rr, r_p_ii, r_p_ri, r_p_ir, r_sq_r, r_sq_i;
    logic signed [W:0]    r_as_re, r_as_im;

    // stage 2: sums
    logic                 r_v2;
    t_func                r_func2;
    logic signed [SW-1:0] r_m_re, r_m_im, r_n_re, r_n_im;
    logic [PW-1:0]        r_den;
    logic signed [W:0]    r_as2_re, r_as2_im;

    // divider stages
    logic [W:0] r_vd;
    t_dv        r_dv [W+1];

    // output
    logic                r_vo;
    logic signed [W-1:0] r_res_re, r_res_im;
    logic                r_ovf, r_dz;

    logic       e_o, e_2, e_1, e_0;
    logic [W:0] e_d;

    always_comb begin
        e_o    = !r_vo || !i_stall;
        e_d[W] = !r_vd[W] || e_o;
        for (int j = W - 1; j >= 0; j--) begin
            e_d[j] = !r_vd[j] || e_d[j+1];
        end
        e_2 = !r_v2 || e_d[0];
        e_1 = !r_v1 || e_2;
        e_0 = !r_v0 || e_1;
    end

    assign o_stall = !e_0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_vd <= '0;
            r_vo <= 1'b0;
        end else begin
            if (e_0) r_v0 <= i_valid;
            if (e_1) r_v1 <= r_v0;
            if (e_2) r_v2 <= r_v1;
            if (e_d[0]) r_vd[0] <= r_v2;
            for (int j = 0; j < W; j++) begin
                if (e_d[j+1]) r_vd[j+1] <= r_vd[j];
            end
            if (e_o) r_vo <= r_vd[W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (e_0) begin
            r_func0 <= t_func'(i_func);
            r_a_re  <= i_a_re;
            r_a_im  <= i_a_im;
            r_b_re  <= i_b_re;
            r_b_im  <= i_b_im;
        end
        if (e_1) begin
            r_func1 <= r_func0;
            r_p_rr  <= r_a_re * r_b_re;
            r_p_ii  <= r_a_im * r_b_im;
            r_p_ri  <= r_a_re * r_b_im;
            r_p_ir  <= r_a_im * r_b_re;
            r_sq_r  <= r_b_re * r_b_re;
            r_sq_i  <= r_b_im * r_b_im;
            if (r_func0 == FUNC_SUB) begin
                r_as_re <= (W+1)'(r_a_re) - (W+1)'(r_b_re);
                r_as_im <= (W+1)'(r_a_im) - (W+1)'(r_b_im);
            end else begin
                r_as_re <= (W+1)'(r_a_re) + (W+1)'(r_b_re);
                r_as_im <= (W+1)'(r_a_im) + (W+1)'(r_b_im);
            end
        end
        if (e_2) begin
            r_func2  <= r_func1;
            r_m_re   <= SW'(r_p_rr) - SW'(r_p_ii);
            r_m_im   <= SW'(r_p_ri) + SW'(r_p_ir);
            r_n_re   <= SW'(r_p_rr) + SW'(r_p_ii);
            r_n_im   <= SW'(r_p_ir) - SW'(r_p_ri);
            r_den    <= PW'(unsigned'(r_sq_r)) + PW'(unsigned'(r_sq_i));
            r_as2_re <= r_as_re;
            r_as2_im <= r_as_im;
        end
    end

    // stage 3: finish add/sub/mul, set up division
    t_dv               n_dv0;
    t_sat              s_re, s_im;
    logic [SW-1:0]     mag_re, mag_im;
    logic [CW-1:0]     den_w;
    logic signed [SW-1:0] sh_re, sh_im;

    always_comb begin
        sh_re = r_m_re >>> FRAC_BITS;
        sh_im = r_m_im >>> FRAC_BITS;
        if (r_func2 == FUNC_MUL) begin
            s_re = sat_s(sh_re);
            s_im = sat_s(sh_im);
        end else begin
            s_re = sat_s(SW'(r_as2_re));
            s_im = sat_s(SW'(r_as2_im));
        end
        mag_re = r_n_re[SW-1] ? SW'(-r_n_re) : SW'(r_n_re);
        mag_im = r_n_im[SW-1] ? SW'(-r_n_im) : SW'(r_n_im);
        den_w  = CW'(r_den) << W;
        n_dv0.func   = r_func2;
        n_dv0.dz     = (r_den == '0);
        n_dv0.ar_re  = s_re.v;
        n_dv0.ar_im  = s_im.v;
        n_dv0.ar_ovf = s_re.o || s_im.o;
        n_dv0.neg_re = r_n_re[SW-1];
        n_dv0.neg_im = r_n_im[SW-1];
        n_dv0.r_re   = CW'(mag_re) << FRAC_BITS;
        n_dv0.r_im   = CW'(mag_im) << FRAC_BITS;
        n_dv0.sat_re = (n_dv0.r_re >= den_w);
        n_dv0.sat_im = (n_dv0.r_im >= den_w);
        n_dv0.den    = r_den;
        n_dv0.q_re   = '0;
        n_dv0.q_im   = '0;
    end

    always_ff @(posedge i_clk) begin
        if (e_d[0]) r_dv[0] <= n_dv0;
    end

    for (genvar j = 0; j < W; j++) begin : g_div
        localparam int K = W - 1 - j;
        t_dv           n_dv;
        logic [CW-1:0] dk;
        always_comb begin
            n_dv = r_dv[j];
            dk   = CW'(r_dv[j].den) << K;
            if (r_dv[j].r_re >= dk) begin
                n_dv.r_re    = r_dv[j].r_re - dk;
                n_dv.q_re[K] = 1'b1;
            end
            if (r_dv[j].r_im >= dk) begin
                n_dv.r_im    = r_dv[j].r_im - dk;
                n_dv.q_im[K] = 1'b1;
            end
        end
        always_ff @(posedge i_clk) begin
            if (e_d[j+1]) r_dv[j+1] <= n_dv;
        end
    end

    t_sat d_re, d_im;
    always_comb begin
        d_re = div_fin(r_dv[W].neg_re && (r_dv[W].q_re != '0), r_dv[W].sat_re, r_dv[W].q_re);
        d_im = div_fin(r_dv[W].neg_im && (r_dv[W].q_im != '0), r_dv[W].sat_im, r_dv[W].q_im);
    end

    always_ff @(posedge i_clk) begin
        if (e_o) begin
            if (r_dv[W].func != FUNC_DIV) begin
                r_res_re <= r_dv[W].ar_re;
                r_res_im <= r_dv[W].ar_im;
                r_ovf    <= r_dv[W].ar_ovf;
                r_dz     <= 1'b0;
            end else if (r_dv[W].dz) begin
                r_res_re <= '0;
                r_res_im <= '0;
                r_ovf    <= 1'b0;
                r_dz     <= 1'b1;
            end else begin
                r_res_re <= d_re.v;
                r_res_im <= d_im.v;
                r_ovf    <= d_re.o || d_im.o;
                r_dz     <= 1'b0;
            end
        end
    end

    assign o_valid       = r_vo;
    assign o_res_re      = r_res_re;
    assign o_res_im      = r_res_im;
    assign o_overflow    = r_ovf;
    assign o_div_by_zero = r_dz;

endmodule

### sv/cau_checker.sv
// ----------------------------------------------------------------------------
// cau_checker
// Port-level checks for the complex arithmetic unit.
// ----------------------------------------------------------------------------
module cau_checker
    import cau_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_stall,
    input logic                  o_valid,
    input logic                  i_stall,
    input logic [DATA_WIDTH-1:0] o_res_re,
    input logic [DATA_WIDTH-1:0] o_res_im,
    input logic                  o_overflow,
    input logic                  o_div_by_zero
);

    localparam logic [DATA_WIDTH-1:0] MAXV = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] MINV = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_res_re) && $stable(o_res_im))
        else $error("stalled result changed");

    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_div_by_zero |-> o_res_re == '0 && o_res_im == '0 && !o_overflow)
        else $error("divide by zero result not clean");

    a_ovf_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_overflow |-> o_res_re == MAXV || o_res_re == MINV
                              || o_res_im == MAXV || o_res_im == MINV)
        else $error("overflow without saturated part");

    a_stall_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled with empty output");

endmodule

bind complex_arithmetic_unit cau_checker #(.DATA_WIDTH(DATA_WIDTH)) u_cau_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_res_re      (o_res_re),
    .o_res_im      (o_res_im),
    .o_overflow    (o_overflow),
    .o_div_by_zero (o_div_by_zero)
);
